[hw/rtl/lst_pkg.sv]
// lst_pkg: item types, action codes, sequencer states and default sizes
// for the linear set table. Used by every module of the block but lst_key_mem.
`default_nettype none

package lst_pkg;

  localparam int LST_CAPACITY  = 16;
  localparam int LST_KEY_WIDTH = 32;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] key;
    logic [3:0]  entry_index;
  } lst_in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] entry_value;
    logic [4:0]  entry_count;
  } lst_out_item_t;

  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_ERASE    = 3'd1;
  localparam logic [2:0] ACT_CONTAINS = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_READ     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_RESOLVE,
    ST_ENTRY_WAIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } lst_state_t;

endpackage

`default_nettype wire

[hw/rtl/lst_key_mem.sv]
// lst_key_mem: key storage, one write port and one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module lst_key_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/lst_ctrl.sv]
// lst_ctrl: sequencer with the shared key comparator, held count and the
// result register. Drives the key memory; uses lst_pkg.
`default_nettype none

module lst_ctrl
  import lst_pkg::*;
#(
  parameter int CAPACITY  = LST_CAPACITY,
  parameter int KEY_WIDTH = LST_KEY_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lst_in_item_t                in_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lst_out_item_t                    out_item,
  output logic                             mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
  output logic [KEY_WIDTH-1:0]             mem_wr_data,
  output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
  input  wire logic [KEY_WIDTH-1:0]        mem_rd_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  lst_state_t      state_r, state_nxt;
  logic [2:0]      act_r, act_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            found_r, found_nxt;
  logic            res_ok_r, res_ok_nxt;
  logic [31:0]     res_val_r, res_val_nxt;
  logic            out_vld_r, out_vld_nxt;
  lst_out_item_t   out_item_r, out_item_nxt;

  logic            accept;
  logic            hit;
  logic            has_next;
  logic            has_next2;
  logic            idx_valid;
  logic            not_full;
  logic            out_free;
  logic [CW:0]     ptr_p1;
  logic [CW:0]     ptr_p2;
  logic [CW:0]     cnt_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign hit       = (mem_rd_data == key_r);
  assign ptr_p1    = (CW + 1)'(ptr_r) + (CW + 1)'(1);
  assign ptr_p2    = (CW + 1)'(ptr_r) + (CW + 1)'(2);
  assign cnt_ext   = (CW + 1)'(count_r);
  assign has_next  = (ptr_p1 < cnt_ext);
  assign has_next2 = (ptr_p2 < cnt_ext);
  assign idx_valid = ((CW + 4)'(in_item.entry_index) < (CW + 4)'(count_r));
  assign not_full  = (count_r < CW'(CAPACITY));
  assign out_free  = !out_vld_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_INSERT, ACT_ERASE, ACT_CONTAINS: begin
              state_nxt = (count_r == '0) ? ST_RESOLVE : ST_SCAN_RD;
            end
            ACT_READ: begin
              state_nxt = idx_valid ? ST_ENTRY_WAIT : ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN_RD:    state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        state_nxt = (hit || !has_next) ? ST_RESOLVE : ST_SCAN_RD;
      end
      ST_RESOLVE: begin
        if (act_r == ACT_ERASE && found_r && has_next) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ENTRY_WAIT: state_nxt = ST_DONE;
      ST_SHIFT_RD:   state_nxt = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        state_nxt = has_next2 ? ST_SHIFT_RD : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    act_nxt      = act_r;
    key_nxt      = key_r;
    ptr_nxt      = ptr_r;
    count_nxt    = count_r;
    found_nxt    = found_r;
    res_ok_nxt   = res_ok_r;
    res_val_nxt  = res_val_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_item_nxt = out_item_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = ptr_r;
    mem_wr_data  = key_r;
    mem_rd_addr  = ptr_r;
    case (state_r)
      ST_IDLE: begin
        mem_rd_addr = AW'(in_item.entry_index);
        if (accept) begin
          act_nxt     = in_item.action;
          key_nxt     = KEY_WIDTH'(in_item.key);
          ptr_nxt     = '0;
          found_nxt   = 1'b0;
          res_ok_nxt  = 1'b0;
          res_val_nxt = '0;
          if (in_item.action == ACT_CLEAR) begin
            count_nxt  = '0;
            res_ok_nxt = 1'b1;
          end
        end
      end
      ST_SCAN_CMP: begin
        if (hit) begin
          found_nxt = 1'b1;
        end else if (has_next) begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_RESOLVE: begin
        case (act_r)
          ACT_INSERT: begin
            if (found_r) begin
              res_ok_nxt = 1'b1;
            end else if (not_full) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = AW'(count_r);
              count_nxt   = count_r + CW'(1);
              res_ok_nxt  = 1'b1;
            end
          end
          ACT_ERASE: begin
            // last entry matched: nothing to shift
            if (found_r && !has_next) begin
              count_nxt  = count_r - CW'(1);
              res_ok_nxt = 1'b1;
            end
          end
          ACT_CONTAINS: res_ok_nxt = found_r;
          default: ;
        endcase
      end
      ST_ENTRY_WAIT: begin
        res_ok_nxt  = 1'b1;
        res_val_nxt = 32'(mem_rd_data);
      end
      ST_SHIFT_RD: begin
        mem_rd_addr = ptr_r + AW'(1);
      end
      ST_SHIFT_WR: begin
        // move the later entry down one place
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
        if (has_next2) begin
          ptr_nxt = ptr_r + AW'(1);
        end else begin
          count_nxt  = count_r - CW'(1);
          res_ok_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_nxt              = 1'b1;
          out_item_nxt.ok          = res_ok_r;
          out_item_nxt.entry_value = res_val_r;
          out_item_nxt.entry_count = 5'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    found_r    <= found_nxt;
    res_ok_r   <= res_ok_nxt;
    res_val_r  <= res_val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[hw/rtl/linear_set_table_top.sv]
// linear_set_table_top: set of distinct keys held as an ordered list.
// Channels: in_valid/in_stall/in_item carry one action with its key and
// index; out_valid/out_stall/out_item return exactly one result per item.
// Every result carries the number of keys held after the action.
// One item is worked at a time; in_stall is high from acceptance until the
// result has been loaded into the output register, which then frees the
// input side while the result waits to be taken.
// Path per item: clear, unused codes and reads past the end go straight to
// the result; a read waits on the key memory; contains, insert and erase
// scan the held entries. The pace is set by the single read port of the key
// memory: a scan reads and compares one entry in ST_SCAN_RD then ST_SCAN_CMP,
// and erase compaction reads and rewrites one entry in ST_SHIFT_RD then
// ST_SHIFT_WR, so an erase visits each held entry once, scanned or shifted.
// Reset (rst_n low, synchronous) empties the list at once; key storage is
// not cleared, since no entry is read before it has been written.
// While out_stall holds a result, the block finishes the next item and then
// waits with its result until the output register is free.
`default_nettype none

module linear_set_table_top
  import lst_pkg::*;
#(
  parameter int CAPACITY  = LST_CAPACITY,
  parameter int KEY_WIDTH = LST_KEY_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lst_in_item_t  in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lst_out_item_t      out_item
);

  localparam int AW = $clog2(CAPACITY);

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [KEY_WIDTH-1:0] mem_wr_data;
  logic [AW-1:0]        mem_rd_addr;
  logic [KEY_WIDTH-1:0] mem_rd_data;

  lst_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  lst_key_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

[bench/lst_result_checker.sv]
`timescale 1ns / 1ps
// lst_result_checker: watches both channels of linear_set_table_top, keeps its own
// copy of the key list and compares every result item with the expected one.
// Depends on lst_pkg for the item types, the action codes and the default sizes.
module lst_result_checker
  import lst_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire lst_in_item_t  in_item,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire lst_out_item_t out_item,
  output int                 mismatch_count,
  output int                 results_owed
);

  localparam int          SLOTS    = LST_CAPACITY;
  localparam logic [31:0] KEY_MASK = {32{1'b1}} >> (32 - LST_KEY_WIDTH);

  logic [31:0]   list_keys [SLOTS];
  int unsigned   list_len = 0;
  lst_out_item_t owed_results [$];
  lst_out_item_t want;
  int            errors = 0;

  assign mismatch_count = errors;

  function automatic int slot_of(logic [31:0] k);
    for (int i = 0; i < list_len; i++) begin
      if (list_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // updates the list copy and returns the result this item should produce
  function automatic lst_out_item_t apply_action(lst_in_item_t it);
    logic [31:0]   k;
    int            pos;
    lst_out_item_t res;
    k = it.key & KEY_MASK;
    pos = slot_of(k);
    res = '0;
    case (it.action)
      ACT_INSERT: begin
        if (pos >= 0) begin
          res.ok = 1'b1;
        end else if (list_len < SLOTS) begin
          list_keys[list_len] = k;
          list_len++;
          res.ok = 1'b1;
        end
      end
      ACT_ERASE: begin
        if (pos >= 0) begin
          // later entries move down one place, order kept
          for (int i = pos; i + 1 < list_len; i++) list_keys[i] = list_keys[i + 1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      ACT_CONTAINS: res.ok = (pos >= 0);
      ACT_CLEAR: begin
        list_len = 0;
        res.ok = 1'b1;
      end
      ACT_READ: begin
        if (it.entry_index < list_len) begin
          res.ok = 1'b1;
          res.entry_value = list_keys[it.entry_index];
        end
      end
      default: ;
    endcase
    res.entry_count = list_len[4:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      owed_results.delete();
    end else begin
      if (in_valid && !in_stall) owed_results.push_back(apply_action(in_item));
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result item with none outstanding: ok=%0b value=%h count=%0d",
                     $time, out_item.ok, out_item.entry_value, out_item.entry_count);
        end else begin
          want = owed_results.pop_front();
          if (out_item.ok !== want.ok || out_item.entry_value !== want.entry_value ||
              out_item.entry_count !== want.entry_count) begin
            errors++;
            if (errors <= 10)
              $display("%0t: expected ok=%0b value=%h count=%0d, got ok=%0b value=%h count=%0d",
                       $time, want.ok, want.entry_value, want.entry_count,
                       out_item.ok, out_item.entry_value, out_item.entry_count);
          end
        end
      end
    end
    results_owed <= owed_results.size();
  end

endmodule

[bench/linear_set_table_top_test.sv]
`timescale 1ns / 1ps
// linear_set_table_top_test: drives actions into linear_set_table_top with random
// gaps and output stalls; results are checked by lst_result_checker.
// Depends on lst_pkg, linear_set_table_top and lst_result_checker.
module linear_set_table_top_test;
  import lst_pkg::*;

  localparam int          IDLE_LIMIT   = 2000;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          POOL_SIZE    = 24;
  localparam logic [2:0]  ACT_SPARE_A  = 3'd5;
  localparam logic [2:0]  ACT_SPARE_B  = 3'd6;
  localparam logic [2:0]  ACT_SPARE_C  = 3'd7;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  lst_in_item_t  in_item   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  lst_out_item_t out_item;

  int          mismatch_count;
  int          results_owed;
  int          items_sent   = 0;
  int          idle_cycles  = 0;
  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [31:0] key_pool [POOL_SIZE];

  linear_set_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  lst_result_checker watcher (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic lst_in_item_t pack_item(logic [2:0] act, logic [31:0] k, logic [3:0] idx);
    lst_in_item_t it;
    it.action = act;
    it.key = k;
    it.entry_index = idx;
    return it;
  endfunction

  // mostly keys from a small pool so that lookups and erases hit
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  task automatic offer(lst_in_item_t it);
    quiet = (items_sent >= 400 && items_sent < 500);
    if (items_sent == 250) hold_off_req = 1'b1;
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int target;
    int n;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, extreme keys, duplicates, shift on erase, spare codes, clear
    offer(pack_item(ACT_READ, '0, 4'd0));
    offer(pack_item(ACT_CONTAINS, '0, 4'd15));
    offer(pack_item(ACT_ERASE, ALL_ONES, 4'd0));
    offer(pack_item(ACT_INSERT, '0, 4'd0));
    offer(pack_item(ACT_INSERT, ALL_ONES, 4'd15));
    offer(pack_item(ACT_INSERT, '0, 4'd0));
    offer(pack_item(ACT_CONTAINS, ALL_ONES, 4'd0));
    offer(pack_item(ACT_CONTAINS, key_pool[2], 4'd0));
    offer(pack_item(ACT_READ, '0, 4'd0));
    offer(pack_item(ACT_READ, ALL_ONES, 4'd1));
    offer(pack_item(ACT_READ, '0, 4'd15));
    offer(pack_item(ACT_ERASE, '0, 4'd0));
    offer(pack_item(ACT_READ, '0, 4'd0));
    offer(pack_item(ACT_ERASE, '0, 4'd0));
    offer(pack_item(ACT_SPARE_A, ALL_ONES, 4'd0));
    offer(pack_item(ACT_SPARE_B, '0, 4'd15));
    offer(pack_item(ACT_SPARE_C, ALL_ONES, 4'd15));
    offer(pack_item(ACT_CLEAR, ALL_ONES, 4'd15));
    offer(pack_item(ACT_READ, '0, 4'd0));
    offer(pack_item(ACT_CONTAINS, ALL_ONES, 4'd0));

    // fill past capacity: the last four inserts are refused
    for (int i = 2; i < 22; i++) offer(pack_item(ACT_INSERT, key_pool[i], 4'd0));
    offer(pack_item(ACT_INSERT, key_pool[5], 4'd0));
    offer(pack_item(ACT_READ, '0, 4'd15));
    offer(pack_item(ACT_ERASE, key_pool[9], 4'd0));
    offer(pack_item(ACT_READ, '0, 4'd15));
    offer(pack_item(ACT_READ, '0, 4'd14));
    offer(pack_item(ACT_INSERT, key_pool[20], 4'd0));
    offer(pack_item(ACT_READ, '0, 4'd15));

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      n = $urandom_range(2, 12);
      case ($urandom_range(9))
        0, 1, 2: repeat (n)
          offer(pack_item(ACT_INSERT, pick_key(), 4'($urandom_range(15))));
        3, 4: repeat (n)
          offer(pack_item($urandom_range(1) ? ACT_ERASE : ACT_CONTAINS, pick_key(),
                          4'($urandom_range(15))));
        5, 6: repeat (n) offer(pack_item(ACT_READ, $urandom(), 4'($urandom_range(15))));
        7: repeat (n) offer(pack_item(ACT_CONTAINS, pick_key(), 4'($urandom_range(15))));
        8: offer(pack_item(ACT_CLEAR, $urandom(), 4'($urandom_range(15))));
        default: repeat (n)
          offer(pack_item(3'($urandom_range(7)), $urandom(), 4'($urandom_range(15))));
      endcase
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lst_pkg.sv
hw/rtl/lst_key_mem.sv
hw/rtl/lst_ctrl.sv
hw/rtl/linear_set_table_top.sv
bench/lst_result_checker.sv
bench/linear_set_table_top_test.sv
